// ===== rtl/core/rfg_pkg.sv =====
// Shared types, constants and helpers for the radio frame generator.
// No dependencies; imported by every module of the block.
`default_nettype none

package rfg_pkg;

    localparam int MAX_RUN_LEN = 16;
    localparam int LEN_W       = 5;
    localparam int CNT_W       = 4;
    localparam int ADDR_W      = 5;

    localparam logic [2:0] REG_PREAMBLE  = 3'd0;
    localparam logic [2:0] REG_SYNC      = 3'd1;
    localparam logic [2:0] REG_POSTAMBLE = 3'd2;
    localparam logic [2:0] REG_FLAG      = 3'd3;
    localparam logic [2:0] REG_SYNC_EVEN = 3'd4;
    localparam logic [2:0] REG_SYNC_ODD  = 3'd5;
    localparam logic [2:0] REG_IDENT     = 3'd6;

    typedef enum logic [2:0] {
        SEC_PRE   = 3'd0,
        SEC_SYNC  = 3'd1,
        SEC_IDENT = 3'd2,
        SEC_PAY   = 3'd3,
        SEC_POST  = 3'd4
    } t_section;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_PRE,
        PH_SYNC,
        PH_IDENT,
        PH_PAY,
        PH_POST
    } t_phase;

    typedef struct packed {
        logic [LEN_W-1:0] pre_len;
        logic [LEN_W-1:0] sync_run;
        logic [LEN_W-1:0] post_len;
        logic [7:0]       flag;
        logic [7:0]       sync_even;
        logic [7:0]       sync_odd;
        logic [23:0]      ident;
    } t_cfg;

    typedef struct packed {
        logic [7:0] data;
        logic       open_hdr;
        logic       pay;
        logic       closing;
    } t_cmd;

    function automatic logic [LEN_W-1:0] sat_len(input logic [LEN_W-1:0] v);
        logic [LEN_W-1:0] lim;
        lim = LEN_W'(MAX_RUN_LEN);
        return (v > lim) ? lim : v;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/rfg_front.sv =====
// Front end: accepts input words, tracks the open frame and classifies each word
// into a command for the back end. Depends on rfg_pkg.
`default_nettype none

module rfg_front (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_valid,
    output logic                o_ready,
    input  wire  [7:0]          i_data,
    input  wire                 i_last,
    input  wire                 i_empty,
    input  rfg_pkg::t_cfg       i_cfg,
    input  wire                 i_q_full,
    output logic                o_push,
    output rfg_pkg::t_cmd       o_cmd
);
    import rfg_pkg::*;

    logic r_inside;
    logic n_inside;
    logic accept;
    logic closing;
    logic drop;

    assign o_ready = !i_q_full;
    assign accept  = i_valid && o_ready;
    assign closing = i_empty || i_last;
    // empty word inside a frame with no postamble leaves nothing to send
    assign drop    = r_inside && i_empty && (i_cfg.post_len == '0);
    assign o_push  = accept && !drop;

    always_comb begin
        o_cmd.data     = i_data;
        o_cmd.open_hdr = !r_inside;
        o_cmd.pay      = !i_empty;
        o_cmd.closing  = closing;
    end

    assign n_inside = accept ? !closing : r_inside;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inside <= 1'b0;
        end else begin
            r_inside <= n_inside;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/rfg_queue.sv =====
// Two-entry command queue between front and back end.
// Depends on rfg_pkg for the command type.
`default_nettype none

module rfg_queue (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_push,
    input  rfg_pkg::t_cmd       i_cmd,
    output logic                o_full,
    input  wire                 i_pop,
    output logic                o_valid,
    output rfg_pkg::t_cmd       o_cmd
);
    import rfg_pkg::*;

    t_cmd       r_mem [2];
    logic       r_wptr;
    logic       r_rptr;
    logic [1:0] r_count;
    logic [1:0] n_count;
    logic       do_push;
    logic       do_pop;

    assign o_full  = (r_count == 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_cmd   = r_mem[r_rptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_comb begin
        n_count = r_count;
        if (do_push && !do_pop) begin
            n_count = r_count + 2'd1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            r_count <= n_count;
            if (do_push) begin
                r_wptr <= !r_wptr;
            end
            if (do_pop) begin
                r_rptr <= !r_rptr;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_cmd;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/rfg_back.sv =====
// Back end: sequences preamble, sync, identifier, payload and postamble bytes
// for each command into an output register. Depends on rfg_pkg.
`default_nettype none

module rfg_back (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  rfg_pkg::t_cfg       i_cfg,
    input  wire                 i_q_valid,
    input  rfg_pkg::t_cmd       i_q_cmd,
    output logic                o_pop,
    output logic                o_valid,
    input  wire                 i_ready,
    output logic [7:0]          o_byte,
    output logic [2:0]          o_section,
    output logic                o_frame_end,
    output logic                o_run_last
);
    import rfg_pkg::*;

    t_phase           r_phase, n_phase;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    t_cmd             r_cmd, n_cmd;

    logic             r_out_valid;
    logic [7:0]       r_out_byte;
    t_section         r_out_sec;
    logic             r_out_end;
    logic             r_out_rlast;

    logic             emit;
    logic             phase_done;
    t_phase           following;
    t_phase           first_ph;
    logic             cmd_last;
    logic [7:0]       cur_byte;
    t_section         cur_sec;
    logic [LEN_W-1:0] cnt_ext;
    logic             take_next;

    assign emit    = (r_phase != PH_IDLE) && (!r_out_valid || i_ready);
    assign cnt_ext = {1'b0, r_cnt};

    // outputs of the sequencer
    always_comb begin
        cur_byte   = i_cfg.flag;
        cur_sec    = SEC_PRE;
        phase_done = 1'b0;
        following  = PH_IDLE;
        unique case (r_phase)
            PH_PRE: begin
                cur_byte   = i_cfg.flag;
                cur_sec    = SEC_PRE;
                phase_done = (cnt_ext == i_cfg.pre_len - LEN_W'(1));
                following  = (i_cfg.sync_run != '0) ? PH_SYNC : PH_IDENT;
            end
            PH_SYNC: begin
                cur_byte   = r_cnt[0] ? i_cfg.sync_odd : i_cfg.sync_even;
                cur_sec    = SEC_SYNC;
                phase_done = (cnt_ext == i_cfg.sync_run - LEN_W'(1));
                following  = PH_IDENT;
            end
            PH_IDENT: begin
                unique case (r_cnt[1:0])
                    2'd0:    cur_byte = i_cfg.ident[23:16];
                    2'd1:    cur_byte = i_cfg.ident[15:8];
                    default: cur_byte = i_cfg.ident[7:0];
                endcase
                cur_sec    = SEC_IDENT;
                phase_done = (r_cnt == CNT_W'(2));
                if (r_cmd.pay) begin
                    following = PH_PAY;
                end else if (r_cmd.closing && (i_cfg.post_len != '0)) begin
                    following = PH_POST;
                end
            end
            PH_PAY: begin
                cur_byte   = r_cmd.data;
                cur_sec    = SEC_PAY;
                phase_done = 1'b1;
                if (r_cmd.closing && (i_cfg.post_len != '0)) begin
                    following = PH_POST;
                end
            end
            PH_POST: begin
                cur_byte   = i_cfg.flag;
                cur_sec    = SEC_POST;
                phase_done = (cnt_ext == i_cfg.post_len - LEN_W'(1));
            end
            default: begin
                cur_byte   = i_cfg.flag;
                cur_sec    = SEC_PRE;
                phase_done = 1'b0;
            end
        endcase
        cmd_last = phase_done && (following == PH_IDLE);
    end

    always_comb begin
        if (i_q_cmd.open_hdr) begin
            if (i_cfg.pre_len != '0) begin
                first_ph = PH_PRE;
            end else if (i_cfg.sync_run != '0) begin
                first_ph = PH_SYNC;
            end else begin
                first_ph = PH_IDENT;
            end
        end else if (i_q_cmd.pay) begin
            first_ph = PH_PAY;
        end else begin
            first_ph = PH_POST;
        end
    end

    assign take_next = (r_phase == PH_IDLE) || (emit && cmd_last);
    assign o_pop     = take_next && i_q_valid;

    // next state of the sequencer
    always_comb begin
        n_phase = r_phase;
        n_cnt   = r_cnt;
        n_cmd   = r_cmd;
        if (take_next) begin
            n_cnt = '0;
            if (i_q_valid) begin
                n_cmd   = i_q_cmd;
                n_phase = first_ph;
            end else begin
                n_phase = PH_IDLE;
            end
        end else if (emit) begin
            if (phase_done) begin
                n_phase = following;
                n_cnt   = '0;
            end else begin
                n_cnt = r_cnt + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_cnt   <= n_cnt;
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd <= n_cmd;
        if (emit) begin
            r_out_byte  <= cur_byte;
            r_out_sec   <= cur_sec;
            r_out_end   <= cmd_last && r_cmd.closing;
            r_out_rlast <= cmd_last;
        end
    end

    assign o_valid     = r_out_valid;
    assign o_byte      = r_out_byte;
    assign o_section   = r_out_sec;
    assign o_frame_end = r_out_end;
    assign o_run_last  = r_out_rlast;

endmodule

`default_nettype wire

// ===== rtl/core/radio_frame_generator.sv =====
// Top level of the radio frame generator: configuration registers, front end,
// command queue and back end. Depends on rfg_pkg, rfg_front, rfg_queue, rfg_back.
//
// Channel   Dir  Payload
// s_axis    in   tdata payload byte, tlast final byte, tuser empty frame
// m_axis    out  tdata out byte, tuser section and run last, tlast frame end
// apb       in   seven registers at byte addresses 0x00 to 0x18
//
// One output byte per cycle while the sink takes words and commands are queued; a word
// that opens a frame emits preamble + sync + 4 bytes (3 for an empty frame), a payload
// word inside a frame one, and a closing word adds the postamble length.
// With the back end idle, a word goes through the queue and phase register to the out register.
// The two-entry command queue stalls s_axis only while it holds two words.
// Reset is synchronous and active low; it clears the open frame and queue state.
`default_nettype none

module radio_frame_generator (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    input  wire                         s_axis_tvalid,
    output logic                        s_axis_tready,
    input  wire  [7:0]                  s_axis_tdata,   // [7:0] payload_byte
    input  wire                         s_axis_tlast,
    input  wire                         s_axis_tuser,   // [0] empty_frame
    output logic                        m_axis_tvalid,
    input  wire                         m_axis_tready,
    output logic [7:0]                  m_axis_tdata,   // [7:0] out_byte
    output logic [3:0]                  m_axis_tuser,   // [2:0] section, [3] run_last
    output logic                        m_axis_tlast,
    input  wire                         psel,
    input  wire                         penable,
    input  wire                         pwrite,
    input  wire  [rfg_pkg::ADDR_W-1:0]  paddr,
    input  wire  [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);
    import rfg_pkg::*;

    logic [LEN_W-1:0] r_pre, r_sync, r_post;
    logic [7:0]       r_flag, r_even, r_odd;
    logic [23:0]      r_ident;
    logic             wen;
    logic [2:0]       reg_idx;
    t_cfg             cfg;

    logic             push, q_full, pop, q_valid;
    t_cmd             f_cmd, q_cmd;
    logic [2:0]       sec;
    logic             run_last;

    assign pready  = 1'b1;
    assign wen     = psel && penable && pwrite;
    assign reg_idx = paddr[ADDR_W-1:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pre   <= LEN_W'(8);
            r_sync  <= LEN_W'(2);
            r_post  <= LEN_W'(4);
            r_flag  <= 8'd126;
            r_even  <= 8'd0;
            r_odd   <= 8'd0;
            r_ident <= 24'h534154;
        end else if (wen) begin
            unique case (reg_idx)
                REG_PREAMBLE:  r_pre   <= pwdata[LEN_W-1:0];
                REG_SYNC:      r_sync  <= pwdata[LEN_W-1:0];
                REG_POSTAMBLE: r_post  <= pwdata[LEN_W-1:0];
                REG_FLAG:      r_flag  <= pwdata[7:0];
                REG_SYNC_EVEN: r_even  <= pwdata[7:0];
                REG_SYNC_ODD:  r_odd   <= pwdata[7:0];
                REG_IDENT:     r_ident <= pwdata[23:0];
                default:       ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_PREAMBLE:  prdata = {{(32-LEN_W){1'b0}}, r_pre};
            REG_SYNC:      prdata = {{(32-LEN_W){1'b0}}, r_sync};
            REG_POSTAMBLE: prdata = {{(32-LEN_W){1'b0}}, r_post};
            REG_FLAG:      prdata = {24'd0, r_flag};
            REG_SYNC_EVEN: prdata = {24'd0, r_even};
            REG_SYNC_ODD:  prdata = {24'd0, r_odd};
            REG_IDENT:     prdata = {8'd0, r_ident};
            default:       prdata = 32'd0;
        endcase
    end

    always_comb begin
        cfg.pre_len   = sat_len(r_pre);
        cfg.sync_run  = sat_len(r_sync);
        cfg.post_len  = sat_len(r_post);
        cfg.flag      = r_flag;
        cfg.sync_even = r_even;
        cfg.sync_odd  = r_odd;
        cfg.ident     = r_ident;
    end

    rfg_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (s_axis_tvalid),
        .o_ready  (s_axis_tready),
        .i_data   (s_axis_tdata),
        .i_last   (s_axis_tlast),
        .i_empty  (s_axis_tuser),
        .i_cfg    (cfg),
        .i_q_full (q_full),
        .o_push   (push),
        .o_cmd    (f_cmd)
    );

    rfg_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (f_cmd),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_cmd   (q_cmd)
    );

    rfg_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_q_valid   (q_valid),
        .i_q_cmd     (q_cmd),
        .o_pop       (pop),
        .o_valid     (m_axis_tvalid),
        .i_ready     (m_axis_tready),
        .o_byte      (m_axis_tdata),
        .o_section   (sec),
        .o_frame_end (m_axis_tlast),
        .o_run_last  (run_last)
    );

    assign m_axis_tuser = {run_last, sec};

endmodule

`default_nettype wire

// ===== rtl/core/rfg_checker.sv =====
// Port-level checks for the radio frame generator, bound to the top level.
// Depends on rfg_pkg for the section codes.
`default_nettype none

module rfg_checker (
    input wire        i_clk,
    input wire        i_rst_n,
    input wire        m_axis_tvalid,
    input wire        m_axis_tready,
    input wire [7:0]  m_axis_tdata,
    input wire [3:0]  m_axis_tuser,
    input wire        m_axis_tlast
);
    import rfg_pkg::*;

    logic r_after_end;

    // track whether the last word taken closed a frame
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_after_end <= 1'b1;
        end else if (m_axis_tvalid && m_axis_tready) begin
            r_after_end <= m_axis_tlast;
        end
    end

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)
            && $stable(m_axis_tlast))
        else $error("output word changed while stalled");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid after reset");

    a_end_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tlast |-> m_axis_tuser[3])
        else $error("frame end without run last");

    a_header: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && r_after_end |->
            (m_axis_tuser[2:0] == SEC_PRE) || (m_axis_tuser[2:0] == SEC_SYNC)
            || (m_axis_tuser[2:0] == SEC_IDENT))
        else $error("new frame does not start with a header");

endmodule

bind radio_frame_generator rfg_checker u_checker (.*);

`default_nettype wire

// ===== tb/sv/radio_frame_generator_tb.sv =====
`timescale 1ns / 1ps
// Self-checking bench for radio_frame_generator: a directed table then random frames,
// every output word checked against a behavioural frame builder (typed rows against their tags). Depends on rfg_pkg.

module radio_frame_generator_tb;

    import rfg_pkg::*;

    localparam int ITEM_TOTAL    = 130;
    localparam int SETTLE_CYCLES = 20;
    localparam int HOLD_LEN      = 300;
    localparam int PRESS_LEN     = 8;

    typedef struct packed {
        logic [7:0] b;
        t_section   sec;
        logic       fe;
        logic       rl;
    } t_air_word;

    typedef enum logic {ROW_ITEM, ROW_SETUP} t_row_kind;

    typedef struct packed {
        t_row_kind  kind;
        logic [1:0] setup;
        logic [7:0] data;
        logic       fin;
        logic       emp;
        logic       typed;
        logic       n_words;
        logic       x_end;
    } t_row;

    // register images per setup, in register order
    localparam logic [31:0] PRESET [4][7] = '{
        '{32'h0, 32'h0, 32'h0, 32'h00, 32'hFF, 32'h55, 32'h00FF_FFFF},
        '{32'hFFFF_FFFF, 32'h0000_003F, 32'h1F, 32'hA5, 32'h00, 32'hFF, 32'hFF00_0000},
        '{32'd16, 32'd17, 32'd16, 32'hFF, 32'h0F, 32'hF0, 32'h00AB_CDEF},
        '{32'd1, 32'd3, 32'd1, 32'h7E, 32'hC3, 32'h3C, 32'h0001_0203}
    };

    localparam t_row PLAN [25] = '{
        '{ROW_ITEM,  2'd0, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
        '{ROW_ITEM,  2'd0, 8'hFF, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0},
        '{ROW_ITEM,  2'd0, 8'h5A, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0},
        '{ROW_ITEM,  2'd0, 8'h00, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0},
        '{ROW_ITEM,  2'd0, 8'h33, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0},
        '{ROW_SETUP, 2'd0, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
        '{ROW_ITEM,  2'd0, 8'h80, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0},
        '{ROW_ITEM,  2'd0, 8'h01, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
        '{ROW_ITEM,  2'd0, 8'h7F, 1'b1, 1'b0, 1'b1, 1'b1, 1'b1},
        '{ROW_ITEM,  2'd0, 8'h10, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
        '{ROW_ITEM,  2'd0, 8'hC3, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0},
        '{ROW_ITEM,  2'd0, 8'h00, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0},
        '{ROW_SETUP, 2'd1, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
        '{ROW_ITEM,  2'd0, 8'hC3, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0},
        '{ROW_ITEM,  2'd0, 8'h3C, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
        '{ROW_ITEM,  2'd0, 8'h96, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0},
        '{ROW_ITEM,  2'd0, 8'hFF, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0},
        '{ROW_SETUP, 2'd2, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
        '{ROW_ITEM,  2'd0, 8'h00, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0},
        '{ROW_ITEM,  2'd0, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
        '{ROW_ITEM,  2'd0, 8'hFF, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0},
        '{ROW_SETUP, 2'd3, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
        '{ROW_ITEM,  2'd0, 8'h55, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0},
        '{ROW_ITEM,  2'd0, 8'h11, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0},
        '{ROW_ITEM,  2'd0, 8'hAA, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0}
    };

    logic                i_clk;
    logic                i_rst_n       = 1'b0;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    logic [7:0]          s_axis_tdata  = 8'h00;
    logic                s_axis_tlast  = 1'b0;
    logic                s_axis_tuser  = 1'b0;
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    logic [7:0]          m_axis_tdata;
    logic [3:0]          m_axis_tuser;
    logic                m_axis_tlast;
    logic                psel          = 1'b0;
    logic                penable       = 1'b0;
    logic                pwrite        = 1'b0;
    logic [ADDR_W-1:0]   paddr         = '0;
    logic [31:0]         pwdata        = '0;
    logic [31:0]         prdata;
    logic                pready;

    // row tags travel alongside the offered word
    logic                row_typed     = 1'b0;
    logic                row_n_words   = 1'b0;
    logic                row_end       = 1'b0;

    logic [4:0]          cnt_pre;
    logic [4:0]          cnt_sync;
    logic [4:0]          cnt_post;
    logic [7:0]          flag_b;
    logic [7:0]          sync_even_b;
    logic [7:0]          sync_odd_b;
    logic [23:0]         ident_w;
    logic                frame_open;
    logic                hold_req      = 1'b0;

    t_air_word           step_words [$];
    t_air_word           bytes_due [$];
    int                  errors   = 0;
    int                  sent     = 0;
    int                  calm_src = 0;
    int                  calm_snk = 0;

    radio_frame_generator uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #1000000;
        $display("FAILURE");
        $finish;
    end

    function automatic int run_of(input logic [4:0] r);
        return (int'(r) > MAX_RUN_LEN) ? MAX_RUN_LEN : int'(r);
    endfunction

    function automatic int pick_gap(inout int calm);
        if (calm > 0) begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 19) == 0) begin
            calm = 30;
        end
        return $urandom_range(0, 6);
    endfunction

    function automatic void put_word(input logic [7:0] b, input t_section sec);
        t_air_word w;
        w.b   = b;
        w.sec = sec;
        w.fe  = 1'b0;
        w.rl  = 1'b0;
        step_words.push_back(w);
    endfunction

    function automatic void frame_predict(input logic [7:0] d, input logic fin, input logic emp);
        int   k;
        logic closing;
        step_words.delete();
        if (!frame_open) begin
            for (k = 0; k < run_of(cnt_pre); k++) put_word(flag_b, SEC_PRE);
            for (k = 0; k < run_of(cnt_sync); k++) begin
                put_word((k % 2 == 1) ? sync_odd_b : sync_even_b, SEC_SYNC);
            end
            put_word(ident_w[23:16], SEC_IDENT);
            put_word(ident_w[15:8], SEC_IDENT);
            put_word(ident_w[7:0], SEC_IDENT);
        end
        if (emp) begin
            closing = 1'b1;
        end else begin
            put_word(d, SEC_PAY);
            closing = fin;
        end
        if (closing) begin
            for (k = 0; k < run_of(cnt_post); k++) put_word(flag_b, SEC_POST);
            if (step_words.size() > 0) step_words[step_words.size()-1].fe = 1'b1;
            frame_open = 1'b0;
        end else begin
            frame_open = 1'b1;
        end
        if (step_words.size() > 0) step_words[step_words.size()-1].rl = 1'b1;
    endfunction

    function automatic void store_reg(input logic [2:0] idx, input logic [31:0] v);
        case (idx)
            REG_PREAMBLE:  cnt_pre     = v[4:0];
            REG_SYNC:      cnt_sync    = v[4:0];
            REG_POSTAMBLE: cnt_post    = v[4:0];
            REG_FLAG:      flag_b      = v[7:0];
            REG_SYNC_EVEN: sync_even_b = v[7:0];
            REG_SYNC_ODD:  sync_odd_b  = v[7:0];
            REG_IDENT:     ident_w     = v[23:0];
            default: ;
        endcase
    endfunction

    function automatic logic [31:0] reg_mask(input logic [2:0] idx);
        case (idx)
            REG_PREAMBLE, REG_SYNC, REG_POSTAMBLE: return 32'h0000_001F;
            REG_IDENT:                             return 32'h00FF_FFFF;
            default:                               return 32'h0000_00FF;
        endcase
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch at %0t: %s got %0h expected %0h", $realtime, what, got, want);
        errors++;
    endtask

    task automatic apb_write(input logic [2:0] idx, input logic [31:0] v);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= v;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        store_reg(idx, v);
        // read back
        @(posedge i_clk);
        psel    <= 1'b1;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (prdata !== (v & reg_mask(idx))) begin
            report_mismatch("register read", prdata, v & reg_mask(idx));
        end
    endtask

    task automatic drain_link();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (bytes_due.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic send_word(input logic [7:0] d, input logic fin, input logic emp,
                             input logic typed, input logic nw, input logic xend);
        int gap;
        gap = pick_gap(calm_src);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= d;
        s_axis_tlast  <= fin;
        s_axis_tuser  <= emp;
        row_typed     <= typed;
        row_n_words   <= nw;
        row_end       <= xend;
        do @(posedge i_clk); while (!(s_axis_tvalid && s_axis_tready));
        sent++;
    endtask

    function automatic logic [31:0] random_reg(input logic [2:0] idx);
        logic [31:0] v;
        int          pick;
        v = $urandom;
        if (idx == REG_PREAMBLE || idx == REG_SYNC || idx == REG_POSTAMBLE) begin
            pick = $urandom_range(0, 9);
            if (pick == 0) v[4:0] = 5'd0;
            else if (pick == 1) v[4:0] = 5'($urandom_range(16, 31));
            else v[4:0] = 5'($urandom_range(1, 5));
        end
        return v;
    endfunction

    always @(posedge i_clk) begin : link_monitor
        t_air_word want;
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready) begin
                frame_predict(s_axis_tdata, s_axis_tlast, s_axis_tuser);
                if (row_typed) begin
                    if (row_n_words) begin
                        want.b   = s_axis_tdata;
                        want.sec = SEC_PAY;
                        want.fe  = row_end;
                        want.rl  = 1'b1;
                        bytes_due.push_back(want);
                    end
                end else begin
                    foreach (step_words[k]) bytes_due.push_back(step_words[k]);
                end
            end
            if (m_axis_tvalid && m_axis_tready) begin
                if (bytes_due.size() == 0) begin
                    report_mismatch("word with none expected", 32'(m_axis_tdata), 32'h0);
                end else begin
                    want = bytes_due.pop_front();
                    if (m_axis_tdata !== want.b) begin
                        report_mismatch("out byte", 32'(m_axis_tdata), 32'(want.b));
                    end
                    if (m_axis_tuser[2:0] !== want.sec) begin
                        report_mismatch("section", 32'(m_axis_tuser[2:0]), 32'(want.sec));
                    end
                    if (m_axis_tlast !== want.fe) begin
                        report_mismatch("frame end", 32'(m_axis_tlast), 32'(want.fe));
                    end
                    if (m_axis_tuser[3] !== want.rl) begin
                        report_mismatch("run last", 32'(m_axis_tuser[3]), 32'(want.rl));
                    end
                end
            end
        end
    end

    initial begin : sink
        int   w;
        logic hold_done;
        hold_done = 1'b0;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            if (hold_req && !hold_done) begin
                hold_done = 1'b1;
                w = HOLD_LEN;
            end else begin
                w = pick_gap(calm_snk);
            end
            if (w > 0) begin
                m_axis_tready <= 1'b0;
                repeat (w) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!(m_axis_tvalid && m_axis_tready));
        end
    end

    initial begin : source
        int i;
        int r;
        int f;
        int k;
        int len;
        int pick;
        store_reg(REG_PREAMBLE, 32'd8);
        store_reg(REG_SYNC, 32'd2);
        store_reg(REG_POSTAMBLE, 32'd4);
        store_reg(REG_FLAG, 32'd126);
        store_reg(REG_SYNC_EVEN, 32'd0);
        store_reg(REG_SYNC_ODD, 32'd0);
        store_reg(REG_IDENT, 32'h0053_4154);
        frame_open = 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (i = 0; i < 25; i++) begin
            if (PLAN[i].kind == ROW_SETUP) begin
                drain_link();
                for (r = 0; r < 7; r++) apb_write(3'(r), PRESET[PLAN[i].setup][r]);
            end else begin
                send_word(PLAN[i].data, PLAN[i].fin, PLAN[i].emp,
                          PLAN[i].typed, PLAN[i].n_words, PLAN[i].x_end);
            end
        end

        // keep offering while the sink holds off, so the block fills and stalls
        drain_link();
        hold_req = 1'b1;
        for (k = 0; k < PRESS_LEN; k++) begin
            send_word(8'($urandom), k == PRESS_LEN - 1, 1'b0, 1'b0, 1'b0, 1'b0);
        end

        while (sent < ITEM_TOTAL) begin
            drain_link();
            for (r = 0; r < 7; r++) apb_write(3'(r), random_reg(3'(r)));
            for (f = $urandom_range(2, 5); f > 0; f--) begin
                pick = $urandom_range(0, 9);
                if (pick == 0) begin
                    send_word(8'($urandom), 1'($urandom_range(0, 1)), 1'b1, 1'b0, 1'b0, 1'b0);
                end else if (pick == 1) begin
                    send_word(8'($urandom), 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                              1'b0, 1'b0, 1'b0);
                end else begin
                    len = $urandom_range(1, 6);
                    for (k = 0; k < len; k++) begin
                        // break the frame with an empty request now and then
                        if (k > 0 && $urandom_range(0, 15) == 0) begin
                            send_word(8'($urandom), 1'b0, 1'b1, 1'b0, 1'b0, 1'b0);
                        end
                        send_word(8'($urandom), k == len - 1, 1'b0, 1'b0, 1'b0, 1'b0);
                    end
                end
            end
        end

        drain_link();
        if (errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/core/rfg_pkg.sv
rtl/core/rfg_front.sv
rtl/core/rfg_queue.sv
rtl/core/rfg_back.sv
rtl/core/radio_frame_generator.sv
rtl/core/rfg_checker.sv
tb/sv/radio_frame_generator_tb.sv
